@@ rtl/core/iee_pkg.sv @@
// shared constants, types and helpers for the ising energy evaluator
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps

package iee_pkg;

    localparam int SPIN_COUNT_SET = 8;
    localparam int MAX_SPINS      = 8;
    localparam int SPIN_COUNT     = (SPIN_COUNT_SET > MAX_SPINS) ? MAX_SPINS : SPIN_COUNT_SET;

    localparam int STATE_W    = 8;   // width of the spin state port
    localparam int MASK_BITS  = 28;
    localparam int FIELD_W    = 8;
    localparam int WEIGHTS_W  = FIELD_W * MAX_SPINS;
    localparam int ENERGY_W   = 12;
    localparam int CNT_W      = 4;   // up to seven neighbours per spin
    localparam int COUPLE_SH  = 4;   // one coupling unit is 16 in 1/16 units

    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 64;

    // register select, taken from paddr[3]
    localparam logic REG_COUPLING = 1'b0;
    localparam logic REG_FIELD    = 1'b1;

    // per-cell settings derived from the config registers
    typedef struct packed {
        logic [SPIN_COUNT-1:0]     row;    // coupled lower neighbours of this spin
        logic [SPIN_COUNT-1:0]     sel;    // one-hot position of this spin
        logic signed [FIELD_W-1:0] field;
    } t_cell_cfg;

    // bit of the lower-triangle mask that holds pair (j,k), k < j
    function automatic int pair_bit(input int j, input int k);
        return (j * (j - 1)) / 2 + k;
    endfunction

endpackage

@@ rtl/core/iee_cell.sv @@
// one spin cell of the energy chain: adds this spin's field and coupling terms
// to the running energy and hands the beat on; depends on iee_pkg
`timescale 1ns / 1ps

module iee_cell
    import iee_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_cfg                  i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SPIN_COUNT-1:0]      i_state,
    input  logic signed [ENERGY_W-1:0] i_energy,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [SPIN_COUNT-1:0]      o_state,
    output logic signed [ENERGY_W-1:0] o_energy
);

    logic                       r_valid;
    logic [SPIN_COUNT-1:0]      r_state;
    logic signed [ENERGY_W-1:0] r_energy;

    logic [CNT_W-1:0]           w_match;
    logic [CNT_W-1:0]           w_links;
    logic signed [CNT_W+1:0]    w_sum;
    logic signed [ENERGY_W-1:0] w_term;
    logic signed [ENERGY_W-1:0] w_delta;
    logic                       w_spin;
    logic                       w_take;

    // neighbours aligned minus anti-aligned = 2*aligned_up - links, counted over
    // the signed spins: aligned means neighbour bit equals own spin, so count up
    // spins and fold in own sign afterwards
    always_comb begin
        w_match = '0;
        w_links = '0;
        for (int k = 0; k < SPIN_COUNT; k++) begin
            w_match = w_match + CNT_W'(i_cfg.row[k] & i_state[k]);
            w_links = w_links + CNT_W'(i_cfg.row[k]);
        end
        w_sum   = $signed({1'b0, w_match, 1'b0}) - $signed({2'b00, w_links});
        w_term  = ENERGY_W'(w_sum) * $signed(ENERGY_W'(1 << COUPLE_SH))
                  - ENERGY_W'(i_cfg.field);
        w_spin  = |(i_cfg.sel & i_state);
        w_delta = w_spin ? w_term : -w_term;
    end

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (w_take) begin
            r_state  <= i_state;
            r_energy <= i_energy + w_delta;
        end
    end

    assign o_valid  = r_valid;
    assign o_state  = r_state;
    assign o_energy = r_energy;

    // a held beat keeps its energy
    a_hold_energy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_energy)))
        else $error("cell energy changed while stalled");

    // an empty cell always takes a beat
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("empty cell refused a beat");

    // a taken beat shows up in the next cycle
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_valid)
        else $error("taken beat lost");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("cell not empty after reset");

endmodule

@@ rtl/core/ising_energy_evaluator_unit.sv @@
// an accepted input beat passes through the chain of spin cells to its energy beat,
// one cell per spin, each with its own elastic register; throughput: one spin state
// per cycle while the result channel does not stall
// reset (synchronous, active low): empties the chain, clears both registers
// holds the apb register file and the cell chain; depends on iee_pkg, iee_cell
`timescale 1ns / 1ps

module ising_energy_evaluator_unit
    import iee_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // apb config port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    // input channel
    input  logic                       i_spin_valid,
    output logic                       o_spin_ready,
    input  logic [STATE_W-1:0]         i_spin_state,
    // result channel
    output logic                       o_energy_valid,
    input  logic                       i_energy_ready,
    output logic signed [ENERGY_W-1:0] o_energy
);

    logic [MASK_BITS-1:0] r_coupling;
    logic [WEIGHTS_W-1:0] r_field;
    logic                 w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling <= '0;
            r_field    <= '0;
        end else if (w_wr) begin
            unique case (paddr[3])
                REG_COUPLING: r_coupling <= pwdata[MASK_BITS-1:0];
                REG_FIELD:    r_field    <= pwdata;
                default:      r_field    <= r_field;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_COUPLING: prdata = {{(PDATA_W-MASK_BITS){1'b0}}, r_coupling};
            REG_FIELD:    prdata = r_field;
            default:      prdata = '0;
        endcase
    end

    // cell chain
    logic                       w_valid [0:SPIN_COUNT];
    logic                       w_ready [0:SPIN_COUNT];
    logic [SPIN_COUNT-1:0]      w_state [0:SPIN_COUNT];
    logic signed [ENERGY_W-1:0] w_energy[0:SPIN_COUNT];
    t_cell_cfg                  w_cfg   [0:SPIN_COUNT-1];

    assign w_valid[0]  = i_spin_valid;
    assign o_spin_ready = w_ready[0];
    assign w_state[0]  = i_spin_state[SPIN_COUNT-1:0];
    assign w_energy[0] = '0;

    for (genvar j = 0; j < SPIN_COUNT; j++) begin : g_cell
        for (genvar k = 0; k < SPIN_COUNT; k++) begin : g_row
            if (k < j) begin : g_pair
                assign w_cfg[j].row[k] = r_coupling[pair_bit(j, k)];
            end else begin : g_none
                assign w_cfg[j].row[k] = 1'b0;
            end
            assign w_cfg[j].sel[k] = (k == j);
        end
        assign w_cfg[j].field = $signed(r_field[FIELD_W*j +: FIELD_W]);

        iee_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (w_cfg[j]),
            .i_valid  (w_valid[j]),
            .o_ready  (w_ready[j]),
            .i_state  (w_state[j]),
            .i_energy (w_energy[j]),
            .o_valid  (w_valid[j+1]),
            .i_ready  (w_ready[j+1]),
            .o_state  (w_state[j+1]),
            .o_energy (w_energy[j+1])
        );
    end

    // last cell register is the output stage
    assign o_energy_valid       = w_valid[SPIN_COUNT];
    assign w_ready[SPIN_COUNT]  = i_energy_ready;
    assign o_energy             = w_energy[SPIN_COUNT];

    logic w_unused;
    assign w_unused = ^w_state[SPIN_COUNT];

endmodule

@@ tb/tb_top.sv @@
// testbench for the ising energy evaluator: drives spin states with random gaps,
// checks every energy beat against an in-bench energy calculation
// depends on iee_pkg and ising_energy_evaluator_unit
`timescale 1ns / 1ps

module tb_top;
    import iee_pkg::*;

    localparam int LIMIT_CYCLES    = 200_000;
    localparam int COUPLING_WEIGHT = 1 << COUPLE_SH;
    localparam int MAX_REPORTS     = 200;
    localparam int ITEMS_PER_SET   = 67;

    localparam logic [PADDR_W-1:0] ADDR_COUPLING = {REG_COUPLING, 3'b000};
    localparam logic [PADDR_W-1:0] ADDR_FIELD    = {REG_FIELD, 3'b000};

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       psel           = 1'b0;
    logic                       penable        = 1'b0;
    logic                       pwrite         = 1'b0;
    logic [PADDR_W-1:0]         paddr          = '0;
    logic [PDATA_W-1:0]         pwdata         = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       i_spin_valid   = 1'b0;
    logic                       o_spin_ready;
    logic [STATE_W-1:0]         i_spin_state   = '0;
    logic                       o_energy_valid;
    logic                       i_energy_ready = 1'b0;
    logic signed [ENERGY_W-1:0] o_energy;

    // shadow copies of the two registers
    logic [MASK_BITS-1:0]       coupling_cfg = '0;
    logic [WEIGHTS_W-1:0]       field_cfg    = '0;

    logic signed [ENERGY_W-1:0] pending_energy[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int states_sent   = 0;
    int energies_seen = 0;
    int config_writes = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    ising_energy_evaluator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_spin_valid   (i_spin_valid),
        .o_spin_ready   (o_spin_ready),
        .i_spin_state   (i_spin_state),
        .o_energy_valid (o_energy_valid),
        .i_energy_ready (i_energy_ready),
        .o_energy       (o_energy)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t timeout after %0d cycles, %0d energies outstanding",
                     $time, cycle_count, pending_energy.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // energy of one spin state under the current shadow registers
    function automatic logic signed [ENERGY_W-1:0] ising_energy(input logic [STATE_W-1:0] st);
        int total;
        int sj;
        int sk;
        logic signed [FIELD_W-1:0] h;
        total = 0;
        for (int j = 0; j < SPIN_COUNT; j++) begin
            sj = st[j] ? 1 : -1;
            h  = field_cfg[FIELD_W*j +: FIELD_W];
            total -= int'(h) * sj;
            for (int k = 0; k < j; k++) begin
                sk = st[k] ? 1 : -1;
                // lower triangle, row-major
                if (coupling_cfg[(j * (j - 1)) / 2 + k])
                    total += COUPLING_WEIGHT * sj * sk;
            end
        end
        return total[ENERGY_W-1:0];
    endfunction

    // result side: random back-pressure and in-order comparison
    always @(posedge i_clk) begin
        if (i_rst_n && o_energy_valid && i_energy_ready) begin
            energies_seen++;
            if (pending_energy.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t unexpected energy beat: expected none, actual %0d",
                             $time, o_energy);
            end else begin
                if (o_energy !== pending_energy[0]) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t energy mismatch: expected %0d, actual %0d",
                                 $time, pending_energy[0], o_energy);
                end
                void'(pending_energy.pop_front());
            end
        end
        i_energy_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sender holds off until every outstanding energy has come back
    task automatic drain_pipeline();
        i_spin_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_energy.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic sel, input logic [PDATA_W-1:0] value);
        drain_pipeline();
        case (sel)
            REG_COUPLING: begin
                apb_write(ADDR_COUPLING, value);
                coupling_cfg = value[MASK_BITS-1:0];
            end
            REG_FIELD: begin
                apb_write(ADDR_FIELD, value);
                field_cfg = value[WEIGHTS_W-1:0];
            end
        endcase
        config_writes++;
    endtask

    task automatic send_spin(input logic [STATE_W-1:0] st);
        while ($urandom_range(99) < send_idle_pct) begin
            i_spin_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_spin_valid <= 1'b1;
        i_spin_state <= st;
        @(posedge i_clk);
        while (!o_spin_ready) @(posedge i_clk);
        pending_energy.push_back(ising_energy(st));
        states_sent++;
    endtask

    // registers out of reset must give zero energy for any state
    task automatic test_reset_state();
        send_spin(8'h00);
        send_spin(8'hFF);
        send_spin(8'h55);
    endtask

    task automatic test_local_fields();
        write_register(REG_COUPLING, '0);
        write_register(REG_FIELD, 64'h8080_8080_8080_8080);
        send_spin(8'h00);
        send_spin(8'hFF);
        write_register(REG_FIELD, 64'h7F7F_7F7F_7F7F_7F7F);
        send_spin(8'h00);
        send_spin(8'hFF);
        // neighbouring lanes get different bytes so a misplaced lane shows up
        write_register(REG_FIELD, 64'h807F_0102_FE01_7F80);
        send_spin(8'h01);
        send_spin(8'h80);
        send_spin(8'h3C);
    endtask

    task automatic test_couplings();
        write_register(REG_FIELD, '0);
        // upper bits beyond the triangle must be dropped
        write_register(REG_COUPLING, 64'hFFFF_FFFF_FFFF_FFFF);
        send_spin(8'h00);
        send_spin(8'hFF);
        send_spin(8'h0F);
        send_spin(8'hAA);
        write_register(REG_COUPLING, 64'h1);
        send_spin(8'h01);
        write_register(REG_COUPLING, 64'h1 << (MASK_BITS - 1));
        send_spin(8'h40);
        send_spin(8'hC0);
    endtask

    task automatic test_energy_extremes();
        write_register(REG_COUPLING, {{(PDATA_W-MASK_BITS){1'b0}}, {MASK_BITS{1'b1}}});
        write_register(REG_FIELD, 64'h8080_8080_8080_8080);
        send_spin(8'hFF);
        send_spin(8'h00);
        send_spin(8'h81);
    endtask

    task automatic test_random_phases();
        logic [PDATA_W-1:0] mask_val;
        logic [PDATA_W-1:0] field_val;
        for (int mode = 0; mode < 3; mode++) begin
            drain_pipeline();
            case (mode)
                0: begin send_idle_pct = 10; recv_idle_pct = 61; end
                1: begin send_idle_pct = 61; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int set = 0; set < 5; set++) begin
                case (set)
                    0: begin mask_val = '0;  field_val = 64'h8080_8080_8080_8080; end
                    1: begin mask_val = '1;  field_val = 64'h7F7F_7F7F_7F7F_7F7F; end
                    2: begin mask_val = '1;  field_val = '1; end
                    default: begin
                        mask_val  = {$urandom, $urandom};
                        field_val = {$urandom, $urandom};
                    end
                endcase
                write_register(REG_COUPLING, mask_val);
                write_register(REG_FIELD, field_val);
                for (int n = 0; n < ITEMS_PER_SET; n++)
                    send_spin(STATE_W'($urandom));
            end
        end
    endtask

    initial begin
        send_idle_pct = 10;
        recv_idle_pct = 61;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_local_fields();
        test_couplings();
        test_energy_extremes();
        test_random_phases();

        drain_pipeline();
        repeat (SPIN_COUNT + 4) @(posedge i_clk);

        $display("run covered %0d spin states over %0d register writes, %0d energy beats",
                 states_sent, config_writes, energies_seen);
        $display("field and coupling extremes, oversized mask, three back-pressure mixes;");
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && pending_energy.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
